// File: rtl/nsf_pkg.sv
// shared types, constants and token tables of the nic sector image framer
package nsf_pkg;

  // data bytes in one sector frame and the width of the byte counter
  localparam int DATA_BYTES = 349;
  localparam int CNT_W      = 9;

  // input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // token index within one item
  localparam int TOK_IDX_W = 5;
  localparam int HDR_LEN   = 30;

  // header layout
  localparam logic [TOK_IDX_W-1:0] HDR_ENC_FIRST = TOK_IDX_W'(18);
  localparam logic [TOK_IDX_W-1:0] HDR_ENC_LAST  = TOK_IDX_W'(25);
  localparam logic [TOK_IDX_W-1:0] HDR_LAST_IDX  = TOK_IDX_W'(HDR_LEN - 1);

  // tail layout of the final data byte: the data byte itself, then the tokens after it
  localparam logic [TOK_IDX_W-1:0] TAIL_DATA_IDX = TOK_IDX_W'(0);
  localparam logic [TOK_IDX_W-1:0] TAIL_FF_IDX   = TOK_IDX_W'(1);
  localparam logic [TOK_IDX_W-1:0] TAIL_ZERO_IDX = TOK_IDX_W'(2);
  localparam logic [TOK_IDX_W-1:0] TAIL_CRC_IDX  = TOK_IDX_W'(3);

  localparam logic [7:0] MARK      = 8'hAA;
  localparam logic [7:0] BYTE_FF   = 8'hff;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [6:0] REP_ONE   = 7'd1;
  localparam logic [6:0] REP_NONE  = 7'd0;
  localparam logic [6:0] REP_GAP   = 7'd14;
  localparam logic [6:0] REP_FILL  = 7'd96;
  localparam logic [6:0] REP_CRC   = 7'd2;

  // header bytes; the address field slots are filled in by the encoder
  localparam logic [7:0] HDR_BYTE [HDR_LEN] = '{
    8'hff, 8'hfe, 8'hff,
    8'h03, 8'hfc, 8'hff, 8'h3f, 8'hcf, 8'hf3,
    8'hfc, 8'hff, 8'h3f, 8'hcf, 8'hf3, 8'hfc,
    8'hD5, 8'hAA, 8'h96,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'hDE, 8'hAA, 8'hEB, 8'hff
  };

  // header repeat counts
  localparam logic [6:0] HDR_REP [HDR_LEN] = '{
    7'd1, 7'd1, 7'd22,
    7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1,
    7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1,
    7'd1, 7'd1, 7'd1,
    7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1,
    7'd1, 7'd1, 7'd1, 7'd5
  };

  // what an accepted item turns into
  typedef enum logic [1:0] {
    KIND_START,
    KIND_DATA,
    KIND_DATA_LAST,
    KIND_ERROR
  } kind_t;

  // captured item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] volume;
    logic [7:0] track;
    logic [7:0] sector;
    logic [7:0] data;
  } item_t;

  // one run-length token
  typedef struct packed {
    logic [7:0] val;
    logic [6:0] rep;
    logic       last;
    logic       err;
  } tok_t;

  // index of the final token of an item
  function automatic logic [TOK_IDX_W-1:0] tok_last_idx(input kind_t kind);
    logic [TOK_IDX_W-1:0] r;
    case (kind)
      KIND_START:     r = HDR_LAST_IDX;
      KIND_DATA_LAST: r = TAIL_CRC_IDX;
      default:        r = TAIL_DATA_IDX;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/nsf_if.sv
// valid/ready channel interfaces for items and result tokens
interface nsf_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] volume;
  logic [7:0] track;
  logic [7:0] sector;
  logic [7:0] data;

  modport source (output valid, cmd, volume, track, sector, data, input ready);
  modport sink   (input valid, cmd, volume, track, sector, data, output ready);
endinterface

interface nsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [6:0] repeat_res;
  logic       last;
  logic       error;

  modport source (output valid, out_byte, repeat_res, last, error, input ready);
  modport sink   (input valid, out_byte, repeat_res, last, error, output ready);
endinterface

// File: rtl/nsf_item_stage.sv
// input register: frame tracking, item capture and token index
module nsf_item_stage
  import nsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_cmd,
  input  logic [7:0]           in_volume,
  input  logic [7:0]           in_track,
  input  logic [7:0]           in_sector,
  input  logic [7:0]           in_data,
  output logic                 in_ready,
  input  logic                 adv_ok,
  output logic                 item_valid,
  output item_t                item,
  output logic [TOK_IDX_W-1:0] tok_idx
);

  logic                 item_valid_r, item_valid_nxt;
  item_t                item_r, item_nxt;
  logic [TOK_IDX_W-1:0] idx_r, idx_nxt;
  logic                 in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0]     bytes_taken_r, bytes_taken_nxt;
  logic                 take, final_tok, accept;
  kind_t                kind_new;

  // token leaves this stage when the result register can take it
  assign take      = item_valid_r && adv_ok;
  assign final_tok = (idx_r == tok_last_idx(item_r.kind));
  assign in_ready  = !item_valid_r || (take && final_tok);
  assign accept    = in_valid && in_ready;

  // classify the incoming item and update frame state
  always_comb begin
    in_frame_nxt    = in_frame_r;
    bytes_taken_nxt = bytes_taken_r;
    kind_new        = KIND_ERROR;
    if (in_cmd == CMD_START) begin
      kind_new        = KIND_START;
      in_frame_nxt    = 1'b1;
      bytes_taken_nxt = '0;
    end else if (in_frame_r) begin
      if (bytes_taken_r == CNT_W'(DATA_BYTES - 1)) begin
        kind_new        = KIND_DATA_LAST;
        in_frame_nxt    = 1'b0;
        bytes_taken_nxt = '0;
      end else begin
        kind_new        = KIND_DATA;
        bytes_taken_nxt = bytes_taken_r + CNT_W'(1);
      end
    end
  end

  // item register and token index
  always_comb begin
    item_valid_nxt = item_valid_r;
    item_nxt       = item_r;
    idx_nxt        = idx_r;
    if (accept) begin
      item_valid_nxt  = 1'b1;
      item_nxt.kind   = kind_new;
      item_nxt.volume = in_volume;
      item_nxt.track  = in_track;
      item_nxt.sector = in_sector;
      item_nxt.data   = in_data;
      idx_nxt         = '0;
    end else if (take) begin
      if (final_tok) begin
        item_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + TOK_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r  <= 1'b0;
      in_frame_r    <= 1'b0;
      bytes_taken_r <= '0;
      idx_r         <= '0;
    end else begin
      item_valid_r <= item_valid_nxt;
      idx_r        <= idx_nxt;
      if (accept) begin
        in_frame_r    <= in_frame_nxt;
        bytes_taken_r <= bytes_taken_nxt;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = item_valid_r;
  assign item       = item_r;
  assign tok_idx    = idx_r;

endmodule

// File: rtl/nsf_token_gen.sv
// builds the token at the current index of the captured item
module nsf_token_gen
  import nsf_pkg::*;
(
  input  item_t                item,
  input  logic [TOK_IDX_W-1:0] tok_idx,
  output tok_t                 tok
);

  logic [2:0] enc_off;
  logic [7:0] enc_x;
  logic       in_enc;
  logic [7:0] chk;

  // address field: pairs of 4-and-4 encoded bytes
  assign chk     = item.volume ^ item.track ^ item.sector;
  assign enc_off = tok_idx[2:0] - HDR_ENC_FIRST[2:0];
  assign in_enc  = (tok_idx >= HDR_ENC_FIRST) && (tok_idx <= HDR_ENC_LAST);

  always_comb begin
    case (enc_off[2:1])
      2'd0:    enc_x = item.volume;
      2'd1:    enc_x = item.track;
      2'd2:    enc_x = item.sector;
      default: enc_x = chk;
    endcase
  end

  // token selection by item kind
  always_comb begin
    tok = '{val: BYTE_ZERO, rep: REP_ONE, last: 1'b0, err: 1'b0};
    case (item.kind)
      KIND_START: begin
        if (in_enc) begin
          tok.val = enc_off[0] ? (enc_x | MARK) : ({1'b0, enc_x[7:1]} | MARK);
        end else begin
          tok.val = HDR_BYTE[tok_idx];
        end
        tok.rep = HDR_REP[tok_idx];
      end
      KIND_DATA: begin
        tok.val = item.data;
      end
      KIND_DATA_LAST: begin
        case (tok_idx)
          TAIL_FF_IDX: begin
            tok.val = BYTE_FF;
            tok.rep = REP_GAP;
          end
          TAIL_ZERO_IDX: begin
            tok.val = BYTE_ZERO;
            tok.rep = REP_FILL;
          end
          TAIL_CRC_IDX: begin
            tok.val  = BYTE_FF;
            tok.rep  = REP_CRC;
            tok.last = 1'b1;
          end
          default: begin
            tok.val = item.data;
          end
        endcase
      end
      default: begin
        tok.rep = REP_NONE;
        tok.err = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/nsf_out_reg.sv
// result register between token generation and the output channel
module nsf_out_reg
  import nsf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic tok_valid,
  input  tok_t tok,
  output logic adv_ok,
  output logic out_valid,
  input  logic out_ready,
  output tok_t out_tok
);

  logic out_valid_r, out_valid_nxt;
  tok_t tok_r;
  logic load;

  // free when empty or when the held token transfers this cycle
  assign adv_ok = !out_valid_r || out_ready;
  assign load   = tok_valid && adv_ok;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r <= tok;
    end
  end

  assign out_valid = out_valid_r;
  assign out_tok   = tok_r;

endmodule

// File: rtl/nic_sector_image_framer.sv
// Sector image framer: each accepted item produces run-length tokens, one token per
// cycle through a result register while out_ready holds. A start item yields 30 tokens,
// a data byte 1 token, the final data byte of a frame 4 tokens, and a data byte outside
// a frame 1 error token. Rate is set by the single result register, which moves one
// token per cycle unless stalled; a new item is taken in the cycle its previous item's
// final token moves on, so unstalled data bytes stream one per cycle. An item passes the
// item register and its first token the result register before it is presented.
module nic_sector_image_framer
  import nsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  nsf_in_if.sink   in_ch,
  nsf_out_if.source out_ch
);

  logic                 adv_ok;
  logic                 item_valid;
  item_t                item;
  logic [TOK_IDX_W-1:0] tok_idx;
  tok_t                 tok;
  tok_t                 out_tok;
  logic                 in_ready;
  logic                 out_valid;

  // input register and frame state
  nsf_item_stage u_item (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_cmd     (in_ch.cmd),
    .in_volume  (in_ch.volume),
    .in_track   (in_ch.track),
    .in_sector  (in_ch.sector),
    .in_data    (in_ch.data),
    .in_ready   (in_ready),
    .adv_ok     (adv_ok),
    .item_valid (item_valid),
    .item       (item),
    .tok_idx    (tok_idx)
  );

  // token builder
  nsf_token_gen u_gen (
    .item    (item),
    .tok_idx (tok_idx),
    .tok     (tok)
  );

  // result register
  nsf_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (item_valid),
    .tok       (tok),
    .adv_ok    (adv_ok),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_tok   (out_tok)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.out_byte   = out_tok.val;
  assign out_ch.repeat_res = out_tok.rep;
  assign out_ch.last       = out_tok.last;
  assign out_ch.error      = out_tok.err;

endmodule

// File: rtl/nsf_checker.sv
// port-level checks on the framer's result channel, bound to the top level
module nsf_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic [6:0] out_repeat,
  input  logic       out_last,
  input  logic       out_error
);

  // error tokens carry no run and never close a sector
  a_err_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_repeat == 7'd0 && !out_last)
    else $error("error token with nonzero repeat or last");

  // every ordinary token has a run of at least one
  a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error |-> out_repeat != 7'd0)
    else $error("ordinary token with zero repeat");

  // the closing token is the crc filler run
  a_last_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_byte == 8'hff && out_repeat == 7'd2)
    else $error("last token is not the crc filler");

  // a stalled token holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(out_repeat) && $stable(out_last) && $stable(out_error))
    else $error("stalled token changed");

endmodule

bind nic_sector_image_framer nsf_checker u_nsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .out_repeat (out_ch.repeat_res),
  .out_last   (out_ch.last),
  .out_error  (out_ch.error)
);
